@@ hw/rtl/hlf_pkg.sv @@
// hlf_pkg: shared types and constants of the hot/cold block address filter
// command codes, queue item and configuration structs, back-end states
// no dependencies
package hlf_pkg;

    localparam int LBA_W     = 16;
    localparam int CFG_CNT_W = 8;
    localparam int WIN_W     = 24;
    localparam int STAT_W    = 32;
    localparam int CMD_W     = 3;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 96;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    localparam logic [1:0] REG_MAX_COUNT     = 2'd0;
    localparam logic [1:0] REG_HOT_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_WINDOW_LENGTH = 2'd2;

    localparam logic [CFG_CNT_W-1:0] MAX_COUNT_RST     = 8'd15;
    localparam logic [CFG_CNT_W-1:0] HOT_THRESHOLD_RST = 8'd8;
    localparam logic [WIN_W-1:0]     WINDOW_LENGTH_RST = 24'h010000;

    typedef enum logic [CMD_W-1:0] {
        CMD_ACCESS      = 3'd0,
        CMD_CHECK       = 3'd1,
        CMD_RESET_TABLE = 3'd2,
        CMD_CLEAR_STATS = 3'd3,
        CMD_ENABLE      = 3'd4
    } hlf_cmd_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ
    } hlf_state_t;

    typedef struct packed {
        hlf_cmd_t         cmd;
        logic [LBA_W-1:0] lba;
        logic             hot_write;
        logic             arm_build;
        logic             in_range;
    } hlf_item_t;

    typedef struct packed {
        logic [CFG_CNT_W-1:0] max_count;
        logic [CFG_CNT_W-1:0] hot_threshold;
        logic [WIN_W-1:0]     window_length;
    } hlf_cfg_t;

endpackage

@@ hw/rtl/hlf_ram.sv @@
// hlf_ram: generic single-port ram with registered read
// no dependencies
module hlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/hlf_front.sv @@
// hlf_front: input channel, command decode and two-entry command queue
// depends on hlf_pkg
module hlf_front
    import hlf_pkg::*;
#(
    parameter int LBA_COUNT = 65536
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic [CMD_W-1:0]     s_tuser,
    input  logic                 hold,
    output logic                 q_valid,
    input  logic                 q_pop,
    output hlf_item_t            q_item
);

    localparam logic [24:0] LBA_LIMIT = 25'(LBA_COUNT);
    localparam logic [1:0]  Q_FULL    = 2'd2;

    hlf_item_t  q_mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    hlf_item_t  in_item;
    logic       push;

    always_comb begin
        in_item.cmd       = hlf_cmd_t'(s_tuser);
        in_item.lba       = s_tdata[LBA_W-1:0];
        in_item.hot_write = s_tdata[LBA_W];
        in_item.arm_build = s_tdata[LBA_W+1];
        in_item.in_range  = 25'(s_tdata[LBA_W-1:0]) < LBA_LIMIT;
    end

    assign s_tready = (count_reg != Q_FULL) && !hold;
    assign push     = s_tvalid && s_tready;
    assign q_valid  = count_reg != 2'd0;
    assign q_item   = q_mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push  ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ hw/rtl/hlf_back.sv @@
// hlf_back: command execution, counter table sweep and result register
// depends on hlf_pkg and hlf_ram
module hlf_back
    import hlf_pkg::*;
#(
    parameter int LBA_COUNT    = 65536,
    parameter int COUNTER_BITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  hlf_cfg_t              cfg,
    input  logic                  q_valid,
    input  hlf_item_t             q_item,
    output logic                  q_pop,
    output logic                  clearing,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int MEM_DEPTH = (LBA_COUNT < 65536) ? LBA_COUNT : 65536;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int CMP_W     = (COUNTER_BITS > CFG_CNT_W) ? COUNTER_BITS : CFG_CNT_W;
    localparam logic [CMP_W-1:0]  CNT_MAX   = CMP_W'((1 << COUNTER_BITS) - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MEM_DEPTH - 1);
    localparam logic [STAT_W-1:0] STAT_SAT  = '1;

    hlf_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    hlf_item_t         item_reg, item_next;
    logic              build_reg, build_next;
    logic              classify_reg, classify_next;
    logic [WIN_W-1:0]  warmup_reg, warmup_next;
    logic [WIN_W-1:0]  budget_reg, budget_next;
    logic [STAT_W-1:0] hits_reg, hits_next;
    logic [STAT_W-1:0] total_reg, total_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_cold_reg, out_cold_next;
    logic [STAT_W-1:0] out_hits_reg, out_hits_next;
    logic [STAT_W-1:0] out_total_reg, out_total_next;
    logic [WIN_W-1:0]  out_budget_reg, out_budget_next;

    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_addr;
    logic [COUNTER_BITS-1:0] ram_wdata;
    logic [COUNTER_BITS-1:0] ram_rdata;

    logic             out_free;
    logic             load;
    logic             load_cold;
    logic [CMP_W-1:0] ceil_w;
    logic [CMP_W-1:0] rd_ext;
    logic [CMP_W-1:0] thr_ext;
    logic [CMP_W-1:0] bumped;

    hlf_ram #(
        .WIDTH (COUNTER_BITS),
        .DEPTH (MEM_DEPTH)
    ) u_cnt_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign clearing = state_reg == ST_CLEAR;

    always_comb begin
        ceil_w  = (CMP_W'(cfg.max_count) < CNT_MAX) ? CMP_W'(cfg.max_count) : CNT_MAX;
        rd_ext  = CMP_W'(ram_rdata);
        thr_ext = CMP_W'(cfg.hot_threshold);
        bumped  = (rd_ext < ceil_w) ? CMP_W'(rd_ext + 1'b1) : rd_ext;
    end

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        item_next     = item_reg;
        build_next    = build_reg;
        classify_next = classify_reg;
        warmup_next   = warmup_reg;
        budget_next   = budget_reg;
        hits_next     = hits_reg;
        total_next    = total_reg;
        ram_we        = 1'b0;
        ram_addr      = q_item.lba[ADDR_W-1:0];
        ram_wdata     = '0;
        q_pop         = 1'b0;
        load          = 1'b0;
        load_cold     = 1'b1;

        case (state_reg)
            ST_CLEAR: begin
                ram_we        = 1'b1;
                ram_addr      = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop     = 1'b1;
                    item_next = q_item;
                    case (q_item.cmd)
                        CMD_ACCESS: begin
                            if (!build_reg) begin
                                load = 1'b1;
                            end else if (warmup_reg != '0) begin
                                warmup_next = warmup_reg - 1'b1;
                                load        = 1'b1;
                            end else if (!q_item.in_range) begin
                                load = 1'b1;
                            end else begin
                                state_next = ST_READ;
                            end
                        end
                        CMD_CHECK: begin
                            if (classify_reg && q_item.in_range) begin
                                state_next = ST_READ;
                            end else begin
                                load = 1'b1;
                            end
                        end
                        CMD_RESET_TABLE: begin
                            warmup_next   = cfg.window_length;
                            budget_next   = cfg.window_length;
                            build_next    = build_reg || q_item.arm_build;
                            classify_next = 1'b0;
                            clr_addr_next = '0;
                            state_next    = ST_CLEAR;
                            load          = 1'b1;
                        end
                        CMD_CLEAR_STATS: begin
                            build_next    = 1'b0;
                            classify_next = 1'b0;
                            hits_next     = '0;
                            total_next    = '0;
                            warmup_next   = cfg.window_length;
                            budget_next   = cfg.window_length;
                            load          = 1'b1;
                        end
                        CMD_ENABLE: begin
                            classify_next = 1'b1;
                            load          = 1'b1;
                        end
                        default: begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                ram_addr   = item_reg.lba[ADDR_W-1:0];
                load       = 1'b1;
                state_next = ST_IDLE;
                if (item_reg.cmd == CMD_ACCESS) begin
                    ram_we    = 1'b1;
                    ram_wdata = bumped[COUNTER_BITS-1:0];
                    if (item_reg.hot_write && budget_reg != '0) begin
                        budget_next = budget_reg - 1'b1;
                    end
                    if (bumped >= thr_ext && hits_reg != STAT_SAT) begin
                        hits_next = hits_reg + 1'b1;
                    end
                    if (total_reg != STAT_SAT) begin
                        total_next = total_reg + 1'b1;
                    end
                end else begin
                    load_cold = !(rd_ext != '0 && rd_ext >= thr_ext);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next  = load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
        out_cold_next   = out_cold_reg;
        out_hits_next   = out_hits_reg;
        out_total_next  = out_total_reg;
        out_budget_next = out_budget_reg;
        if (load) begin
            out_cold_next   = load_cold;
            out_hits_next   = hits_next;
            out_total_next  = total_next;
            out_budget_next = budget_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            build_reg     <= 1'b0;
            classify_reg  <= 1'b0;
            warmup_reg    <= WINDOW_LENGTH_RST;
            budget_reg    <= WINDOW_LENGTH_RST;
            hits_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            build_reg     <= build_next;
            classify_reg  <= classify_next;
            warmup_reg    <= warmup_next;
            budget_reg    <= budget_next;
            hits_reg      <= hits_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg       <= item_next;
        out_cold_reg   <= out_cold_next;
        out_hits_reg   <= out_hits_next;
        out_total_reg  <= out_total_next;
        out_budget_reg <= out_budget_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_budget_reg, out_total_reg, out_hits_reg, out_cold_reg};

endmodule

@@ hw/rtl/hot_lba_filter.sv @@
// hot_lba_filter: a transaction passes the command queue and the result register;
// table lookups (access, check) also pass ST_READ, which reads the counter ram and,
// for access, writes it back through its single port before the next command pops
// throughput 1 transaction per cycle without lookup while m_ is not stalled; reset
// and every reset-table command start a clearing pass over min(LBA_COUNT, 65536)
// counter addresses during which s_tready is low; aresetn is synchronous, active low
// depends on hlf_pkg, hlf_front, hlf_back, hlf_ram
module hot_lba_filter
    import hlf_pkg::*;
#(
    parameter int LBA_COUNT    = 65536,
    parameter int COUNTER_BITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // lba [15:0], hot_write [16], arm_build [17], zero fill
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // cmd [2:0]
    input  logic [CMD_W-1:0]      s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // is_cold [0], hot_access_count [32:1], total_count [64:33],
    // hot_window_left [88:65], zero fill
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready
);

    hlf_cfg_t   cfg_reg, cfg_next;
    logic [1:0] reg_idx;
    logic       cfg_wr;
    logic       q_valid;
    logic       q_pop;
    hlf_item_t  q_item;
    logic       clearing;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            case (reg_idx)
                REG_MAX_COUNT:     cfg_next.max_count     = pwdata[CFG_CNT_W-1:0];
                REG_HOT_THRESHOLD: cfg_next.hot_threshold = pwdata[CFG_CNT_W-1:0];
                REG_WINDOW_LENGTH: cfg_next.window_length = pwdata[WIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MAX_COUNT:     prdata = PDATA_W'(cfg_reg.max_count);
            REG_HOT_THRESHOLD: prdata = PDATA_W'(cfg_reg.hot_threshold);
            REG_WINDOW_LENGTH: prdata = PDATA_W'(cfg_reg.window_length);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_count     <= MAX_COUNT_RST;
            cfg_reg.hot_threshold <= HOT_THRESHOLD_RST;
            cfg_reg.window_length <= WINDOW_LENGTH_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    hlf_front #(
        .LBA_COUNT (LBA_COUNT)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .hold     (clearing),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    hlf_back #(
        .LBA_COUNT    (LBA_COUNT),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .clearing (clearing),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ hw/rtl/hlf_checker.sv @@
// hlf_checker: port-level assertions for hot_lba_filter, attached by bind
// depends on hlf_pkg and hot_lba_filter
module hlf_checker
    import hlf_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  pready
);

    // no result and no input right after reset, clearing pass in progress
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("hlf: channel active right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("hlf: stalled result changed");

    // hot hits are a subset of counted accesses
    a_hits_le_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[32:1] <= m_tdata[64:33])
        else $error("hlf: hot_access_count above total_count");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("hlf: pready dropped");

endmodule

bind hot_lba_filter hlf_checker u_hlf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);

@@ tb/hot_lba_filter_test.sv @@
// hot_lba_filter_test: self-checking bench for the hot/cold block address filter
// drives commands on the s_ stream and registers over apb, predicts every m_ result
// depends on hlf_pkg and hot_lba_filter
module hot_lba_filter_test;
    import hlf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLEAR_CYCLES = 65536;
    localparam int TABLE_CLEARS = 9;
    localparam int ITEM_BUDGET  = 1800;
    localparam longint CYCLE_LIMIT = 4 * (longint'(TABLE_CLEARS) * CLEAR_CYCLES
                                          + longint'(ITEM_BUDGET) * (17 + 17 + 4));

    typedef struct packed {
        logic              is_cold;
        logic [STAT_W-1:0] hot_count;
        logic [STAT_W-1:0] total;
        logic [WIN_W-1:0]  window_left;
    } verdict_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [CMD_W-1:0]      s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PADDR_W-1:0]    paddr = '0;
    logic [PDATA_W-1:0]    pwdata = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    hot_lba_filter uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // shadow of the filter state
    logic [CFG_CNT_W-1:0] lba_cnt [0:(1 << LBA_W) - 1];
    logic                 build_on;
    logic                 classify_on;
    logic [WIN_W-1:0]     warm_left;
    logic [WIN_W-1:0]     budget_left;
    logic [STAT_W-1:0]    hot_hits;
    logic [STAT_W-1:0]    counted;
    logic [CFG_CNT_W-1:0] cfg_max;
    logic [CFG_CNT_W-1:0] cfg_thr;
    logic [WIN_W-1:0]     cfg_win;

    verdict_t verdicts [$];
    verdict_t want;
    int       errors = 0;
    int       n_sent = 0;
    int       n_checked = 0;
    int       n_clears = 0;
    int       n_hot_checks = 0;
    longint   cycles = 0;
    int       gap_odds = 0;
    int       rdy_odds = 0;
    int       rdy_hold = 0;

    function automatic void clear_counters();
        foreach (lba_cnt[i]) lba_cnt[i] = '0;
    endfunction

    function automatic void predict_filter(logic [CMD_W-1:0] cmd, logic [LBA_W-1:0] lba,
                                           logic hw, logic arm);
        verdict_t             v;
        logic [CFG_CNT_W-1:0] cnt;
        v.is_cold = 1'b1;
        cnt = lba_cnt[lba];
        case (cmd)
            CMD_ACCESS: begin
                if (build_on) begin
                    if (warm_left != 0) begin
                        warm_left--;
                    end else begin
                        if (hw && budget_left != 0) budget_left--;
                        if (cnt < cfg_max) cnt++;
                        lba_cnt[lba] = cnt;
                        if (cnt >= cfg_thr && hot_hits != '1) hot_hits++;
                        if (counted != '1) counted++;
                    end
                end
            end
            CMD_CHECK: begin
                v.is_cold = !(classify_on && cnt != 0 && cnt >= cfg_thr);
                if (!v.is_cold) n_hot_checks++;
            end
            CMD_RESET_TABLE: begin
                clear_counters();
                warm_left = cfg_win;
                budget_left = cfg_win;
                if (arm) build_on = 1'b1;
                classify_on = 1'b0;
                n_clears++;
            end
            CMD_CLEAR_STATS: begin
                build_on = 1'b0;
                classify_on = 1'b0;
                hot_hits = '0;
                counted = '0;
                warm_left = cfg_win;
                budget_left = cfg_win;
            end
            CMD_ENABLE: classify_on = 1'b1;
            default: ;
        endcase
        v.hot_count = hot_hits;
        v.total = counted;
        v.window_left = budget_left;
        verdicts.push_back(v);
        n_sent++;
    endfunction

    function automatic void compare_field(string name, logic [STAT_W-1:0] wanted,
                                          logic [STAT_W-1:0] got);
        if (wanted != got) begin
            $display("%0t mismatch %s: expected %0h actual %0h", $time, name, wanted, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (verdicts.size() == 0) begin
                $display("%0t unexpected result: expected none actual %h", $time, m_tdata);
                errors++;
            end else begin
                want = verdicts.pop_front();
                compare_field("is_cold", STAT_W'(want.is_cold), STAT_W'(m_tdata[0]));
                compare_field("hot_access_count", want.hot_count, m_tdata[32:1]);
                compare_field("total_count", want.total, m_tdata[64:33]);
                compare_field("hot_window_left", STAT_W'(want.window_left),
                              STAT_W'(m_tdata[88:65]));
                n_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout with %0d results outstanding", $time, verdicts.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (rdy_hold > 0) begin
            rdy_hold--;
        end else if (rdy_odds != 0 && $urandom_range(1, rdy_odds) == 1) begin
            m_tready <= 1'b0;
            rdy_hold = $urandom_range(1, 17) - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [LBA_W-1:0] lba, logic hw, logic arm);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17) - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {{(IN_DATA_W - LBA_W - 2){1'b0}}, arm, hw, lba};
        do @(posedge aclk); while (!s_tready);
        predict_filter(cmd, lba, hw, arm);
    endtask

    // drop valid, let every result come back and any table sweep finish
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (verdicts.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [PDATA_W-1:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_MAX_COUNT:     cfg_max = value[CFG_CNT_W-1:0];
            REG_HOT_THRESHOLD: cfg_thr = value[CFG_CNT_W-1:0];
            REG_WINDOW_LENGTH: cfg_win = value[WIN_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_regs(int mx, int thr, int win);
        reg_write(REG_MAX_COUNT, mx);
        reg_write(REG_HOT_THRESHOLD, thr);
        reg_write(REG_WINDOW_LENGTH, win);
    endtask

    task automatic test_idle_defaults();
        gap_odds = 4;
        rdy_odds = 4;
        settle();
        send_cmd(CMD_CHECK, 16'h0000, 1'b0, 1'b1);
        send_cmd(CMD_ACCESS, 16'h1234, 1'b1, 1'b1);
        send_cmd(CMD_ENABLE, 16'hFFFF, 1'b1, 1'b0);
        send_cmd(CMD_CHECK, 16'hFFFF, 1'b0, 1'b0);
        for (int c = CMD_ENABLE + 1; c < (1 << CMD_W); c++) begin
            send_cmd(CMD_W'(c), LBA_W'($urandom), 1'b1, 1'b1);
        end
    endtask

    // warm-up swallows accesses, counter stops at the ceiling, budget holds at zero
    task automatic test_warmup_ceiling();
        settle();
        set_regs(2, 2, 2);
        send_cmd(CMD_RESET_TABLE, 16'h0000, 1'b0, 1'b1);
        repeat (5) send_cmd(CMD_ACCESS, 16'hFFFF, 1'b1, 1'b0);
        send_cmd(CMD_ENABLE, 16'h0000, 1'b0, 1'b0);
        send_cmd(CMD_CHECK, 16'hFFFF, 1'b0, 1'b0);
        send_cmd(CMD_CHECK, 16'h0000, 1'b0, 1'b0);
        send_cmd(CMD_RESET_TABLE, 16'h5555, 1'b1, 1'b0);
        send_cmd(CMD_CHECK, 16'hFFFF, 1'b0, 1'b0);
    endtask

    // a never-written counter stays cold even with a zero threshold
    task automatic test_zero_threshold();
        settle();
        set_regs(1, 0, 0);
        send_cmd(CMD_CLEAR_STATS, 16'h00AA, 1'b0, 1'b0);
        send_cmd(CMD_RESET_TABLE, 16'h00AA, 1'b0, 1'b1);
        send_cmd(CMD_ENABLE, 16'h00AA, 1'b0, 1'b0);
        send_cmd(CMD_CHECK, 16'h00AA, 1'b0, 1'b0);
        send_cmd(CMD_ACCESS, 16'h00AA, 1'b0, 1'b0);
        send_cmd(CMD_ACCESS, 16'h00AA, 1'b1, 1'b0);
        send_cmd(CMD_CHECK, 16'h00AA, 1'b0, 1'b0);
    endtask

    task automatic test_window_extreme();
        settle();
        reg_write(REG_WINDOW_LENGTH, (1 << WIN_W) - 1);
        send_cmd(CMD_CLEAR_STATS, 16'h8000, 1'b1, 1'b1);
        send_cmd(CMD_ACCESS, 16'h8000, 1'b1, 1'b1);
    endtask

    task automatic run_phase(int mx, int thr, int win, int set_size, int access_pct,
                             int n_items);
        int               hot_base;
        int               clear_at;
        int               r;
        logic [CMD_W-1:0] cmd;
        logic [LBA_W-1:0] lba;
        hot_base = $urandom_range(0, (1 << LBA_W) - set_size);
        clear_at = $urandom_range(0, 1) ? n_items * 4 / 5 + $urandom_range(0, n_items / 5 - 1)
                                        : -1;
        settle();
        set_regs(mx, thr, win);
        send_cmd(CMD_RESET_TABLE, LBA_W'($urandom), 1'($urandom_range(0, 1)), 1'b1);
        if ($urandom_range(0, 3) != 0) send_cmd(CMD_ENABLE, LBA_W'($urandom), 1'b0, 1'b0);
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(0, 99);
            if (i == clear_at) cmd = CMD_CLEAR_STATS;
            else if (r < access_pct) cmd = CMD_ACCESS;
            else if (r < 95) cmd = CMD_CHECK;
            else if (r < 98) cmd = CMD_ENABLE;
            else cmd = CMD_W'($urandom_range(CMD_ENABLE + 1, (1 << CMD_W) - 1));
            if ($urandom_range(0, 99) < 85) begin
                lba = LBA_W'(hot_base + $urandom_range(0, set_size - 1));
            end else begin
                lba = LBA_W'($urandom);
            end
            send_cmd(cmd, lba, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_random_traffic();
        int mx;
        gap_odds = 6;
        rdy_odds = 6;
        run_phase(255, 255, $urandom_range(0, 10), 1, 90, 400);
        gap_odds = 0;
        rdy_odds = 3;
        run_phase(1, 1, 0, 64, 60, 330);
        gap_odds = 3;
        rdy_odds = 0;
        mx = $urandom_range(2, 20);
        run_phase(mx, $urandom_range(1, mx), $urandom_range(0, 40), $urandom_range(1, 16),
                  65, 330);
        gap_odds = 10;
        rdy_odds = 10;
        mx = $urandom_range(1, 255);
        run_phase(mx, $urandom_range(1, 255), $urandom_range(0, 40), $urandom_range(1, 8),
                  70, 330);
        gap_odds = 0;
        rdy_odds = 0;
        mx = $urandom_range(2, 12);
        run_phase(mx, $urandom_range(1, mx), $urandom_range(0, 20), $urandom_range(1, 32),
                  65, 330);
    endtask

    initial begin
        clear_counters();
        build_on = 1'b0;
        classify_on = 1'b0;
        cfg_max = MAX_COUNT_RST;
        cfg_thr = HOT_THRESHOLD_RST;
        cfg_win = WINDOW_LENGTH_RST;
        warm_left = WINDOW_LENGTH_RST;
        budget_left = WINDOW_LENGTH_RST;
        hot_hits = '0;
        counted = '0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        test_idle_defaults();
        test_warmup_ceiling();
        test_zero_threshold();
        test_window_extreme();
        test_random_traffic();
        settle();
        repeat (16) @(posedge aclk);
        $display("run covered %0d commands and %0d compared results over %0d cycles",
                 n_sent, n_checked, cycles);
        $display("table clears: %0d, checks that found a hot address: %0d, final hot hits: %0d",
                 n_clears, n_hot_checks, hot_hits);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
